// ----- design/tlca_pkg.sv -----
// Shared types and constants for the two-level cache access unit.
package tlca_pkg;
    localparam int AGE_BITS = 16;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    typedef logic [AGE_BITS-1:0] t_age;
endpackage

// ----- design/tlca_line_store.sv -----
// Line metadata and byte memories for one cache level, with valid bits and clear pass.
module tlca_line_store #(
    parameter int ENTRIES = 64,
    parameter int LINE_BYTES = 16,
    parameter int TAG_BITS = 28
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [$clog2(ENTRIES)-1:0]            i_raddr,
    output logic                                  o_rvalid,
    output logic [TAG_BITS-1:0]                   o_rtag,
    output tlca_pkg::t_age                        o_rage,
    input  logic [$clog2(ENTRIES*LINE_BYTES)-1:0] i_braddr,
    output logic [7:0]                            o_rbyte,
    input  logic                                  i_mwe,
    input  logic [$clog2(ENTRIES)-1:0]            i_maddr,
    input  logic [TAG_BITS-1:0]                   i_mtag,
    input  tlca_pkg::t_age                        i_mage,
    input  logic                                  i_bwe,
    input  logic [$clog2(ENTRIES*LINE_BYTES)-1:0] i_bwaddr,
    input  logic [7:0]                            i_bwdata,
    output logic                                  o_clearing
);
    localparam int AW = $clog2(ENTRIES);
    localparam int BW = $clog2(ENTRIES * LINE_BYTES);
    localparam int NB = ENTRIES * LINE_BYTES;

    logic [ENTRIES-1:0] r_valid;
    logic [TAG_BITS-1:0] r_tag_mem [ENTRIES];
    tlca_pkg::t_age r_age_mem [ENTRIES];
    logic [7:0] r_byte_mem [NB];
    logic [BW:0] r_clr;
    logic [AW-1:0] r_raddr;
    logic [7:0] r_rbyte;
    logic [TAG_BITS-1:0] r_rtag;
    tlca_pkg::t_age r_rage;

    assign o_clearing = (r_clr != NB[BW:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_clr <= '0;
        end else begin
            if (o_clearing) r_clr <= r_clr + 1'b1;
            if (i_mwe) r_valid[i_maddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mwe) begin
            r_tag_mem[i_maddr] <= i_mtag;
            r_age_mem[i_maddr] <= i_mage;
        end
        r_raddr <= i_raddr;
        r_rtag <= r_tag_mem[i_raddr];
        r_rage <= r_age_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_clearing) r_byte_mem[r_clr[BW-1:0]] <= '0;
        else if (i_bwe) r_byte_mem[i_bwaddr] <= i_bwdata;
        r_rbyte <= r_byte_mem[i_braddr];
    end

    assign o_rvalid = r_valid[r_raddr];
    assign o_rtag = r_valid[r_raddr] ? r_rtag : '0;
    assign o_rage = r_valid[r_raddr] ? r_rage : '0;
    assign o_rbyte = r_rbyte;
endmodule

// ----- design/two_level_cache_access_unit.sv -----
// Top level of the two-level byte cache access unit.
// Input channel: i_in_valid / o_in_stall with i_operation, i_address, i_write_data.
// Output channel: o_out_valid / i_out_stall with o_l1_hit, o_l2_hit, o_read_data.
// One item is handled at a time; every item gives exactly one result item.
// Each metadata entry is handled in a read state and then a check state.
// An L1 read hit stops the scan at the matching way and reads its byte.
// A read that misses L1 walks the L2 entries in turn and stops at a hit; a miss at
// both levels returns zero data. An L2 hit reads its byte and, if the L1 set has an
// invalid way, fills that way from L2 with a read and a write state per byte.
// A write scans the L1 ways and writes the L1 victim, then scans all L2 entries and
// writes the L2 victim. The unit returns to idle after each delivery.
// After reset a clearing pass zeroes the byte memories; o_in_stall stays high
// until it is done.
// The result sits in an output register; while i_out_stall is high it holds,
// and the next item is taken once the result has been delivered.
module two_level_cache_access_unit #(
    parameter int L1_SETS = 16,
    parameter int L1_WAYS = 4,
    parameter int L2_ENTRIES = 64,
    parameter int LINE_BYTES = 16,
    parameter int ADDRESS_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [31:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_l1_hit,
    output logic        o_l2_hit,
    output logic [7:0]  o_read_data
);
    localparam int OB = $clog2(LINE_BYTES);
    localparam int TB = ADDRESS_BITS - OB;
    localparam int SB = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
    localparam int WB = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
    localparam int L1N = L1_SETS * L1_WAYS;
    localparam int L1A = $clog2(L1N);
    localparam int L2A = $clog2(L2_ENTRIES);
    localparam int L1B = $clog2(L1N * LINE_BYTES);
    localparam int L2B = $clog2(L2_ENTRIES * LINE_BYTES);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_L1RD = 4'd1;
    localparam logic [3:0] S_L1CK = 4'd2;
    localparam logic [3:0] S_L1BY = 4'd3;
    localparam logic [3:0] S_L2RD = 4'd4;
    localparam logic [3:0] S_L2CK = 4'd5;
    localparam logic [3:0] S_L2BY = 4'd6;
    localparam logic [3:0] S_FRD  = 4'd7;
    localparam logic [3:0] S_FWR  = 4'd8;
    localparam logic [3:0] S_WWR  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;
    localparam logic [3:0] S_BYW  = 4'd11;

    logic [3:0] r_state, n_state;
    logic r_op;
    logic [TB-1:0] r_line;
    logic [OB-1:0] r_off;
    logic [7:0] r_wdata;
    logic [L2A:0] r_idx;
    logic [OB:0] r_bcnt;
    logic r_has_inv;
    logic [L2A-1:0] r_hit;
    logic [WB-1:0] r_inv_way;
    logic [L2A-1:0] r_cand;
    tlca_pkg::t_age r_cand_age;
    logic r_lvl2;
    tlca_pkg::t_age r_hit_age;
    logic r_l1h, r_l2h;
    logic [7:0] r_rd;

    logic [SB-1:0] set_idx;
    logic [L1A-1:0] l1_raddr, l1_maddr;
    logic [L2A-1:0] l2_raddr, l2_maddr;
    logic [L1B-1:0] l1_braddr, l1_bwaddr;
    logic [L2B-1:0] l2_braddr, l2_bwaddr;
    logic l1_v, l2_v, l1_mwe, l2_mwe, l1_bwe, l2_bwe, l1_clr, l2_clr;
    logic [TB-1:0] l1_tag, l2_tag, l1_mtag, l2_mtag;
    tlca_pkg::t_age l1_age, l2_age, l1_mage, l2_mage;
    logic [7:0] l1_byte, l2_byte, l1_bwdata, l2_bwdata;
    logic [WB-1:0] way;
    logic accept, deliver;

    assign set_idx = (L1_SETS > 1) ? SB'(r_line % L1_SETS) : '0;
    assign way = WB'(r_idx);
    assign accept = i_in_valid && !o_in_stall;
    assign deliver = o_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || l1_clr || l2_clr;
    assign o_out_valid = (r_state == S_OUT);
    assign o_l1_hit = r_l1h;
    assign o_l2_hit = r_l2h;
    assign o_read_data = r_rd;

    function automatic tlca_pkg::t_age bump(input tlca_pkg::t_age a);
        return (a == tlca_pkg::AGE_MAX) ? a : a + 1'b1;
    endfunction

    always_comb begin
        l1_raddr = L1A'(set_idx) * L1A'(L1_WAYS) + L1A'(way);
        l2_raddr = L2A'(r_idx);
        l1_braddr = L1B'(l1_raddr) * L1B'(LINE_BYTES) + L1B'(r_off);
        l2_braddr = L2B'(r_hit) * L2B'(LINE_BYTES)
                    + L2B'((r_state == S_FRD) ? r_bcnt[OB-1:0] : r_off);
        l1_mwe = 1'b0; l1_maddr = l1_raddr; l1_mtag = r_line; l1_mage = '0;
        l2_mwe = 1'b0; l2_maddr = r_hit; l2_mtag = r_line; l2_mage = '0;
        l1_bwe = 1'b0; l1_bwaddr = l1_braddr; l1_bwdata = r_wdata;
        l2_bwe = 1'b0; l2_bwaddr = l2_braddr; l2_bwdata = r_wdata;
        if (r_state == S_L1CK && l1_v && l1_tag == r_line && !r_op) begin
            l1_mwe = 1'b1; l1_mage = bump(l1_age);
        end
        if (r_state == S_L2CK && l2_v && l2_tag == r_line && !r_op) begin
            l2_mwe = 1'b1; l2_maddr = l2_raddr; l2_mtag = l2_tag; l2_mage = bump(l2_age);
        end
        if (r_state == S_FWR) begin
            l1_maddr = L1A'(set_idx) * L1A'(L1_WAYS) + L1A'(r_inv_way);
            l1_mwe = (r_bcnt == '0);
            l1_mage = r_hit_age;
            l1_bwe = 1'b1;
            l1_bwaddr = L1B'(l1_maddr) * L1B'(LINE_BYTES) + L1B'(r_bcnt[OB-1:0]);
            l1_bwdata = l2_byte;
        end
        if (r_state == S_WWR) begin
            if (!r_lvl2) begin
                l1_maddr = L1A'(set_idx) * L1A'(L1_WAYS) + L1A'(r_cand);
                l1_mwe = 1'b1; l1_bwe = 1'b1;
                l1_bwaddr = L1B'(l1_maddr) * L1B'(LINE_BYTES) + L1B'(r_off);
            end else begin
                l2_maddr = r_cand; l2_mwe = 1'b1; l2_bwe = 1'b1;
                l2_bwaddr = L2B'(r_cand) * L2B'(LINE_BYTES) + L2B'(r_off);
            end
        end
    end

    tlca_line_store #(.ENTRIES(L1N), .LINE_BYTES(LINE_BYTES), .TAG_BITS(TB)) u_l1 (
        .i_clk, .i_rst_n, .i_raddr(l1_raddr), .o_rvalid(l1_v), .o_rtag(l1_tag),
        .o_rage(l1_age), .i_braddr(l1_braddr), .o_rbyte(l1_byte), .i_mwe(l1_mwe),
        .i_maddr(l1_maddr), .i_mtag(l1_mtag), .i_mage(l1_mage), .i_bwe(l1_bwe),
        .i_bwaddr(l1_bwaddr), .i_bwdata(l1_bwdata), .o_clearing(l1_clr));

    tlca_line_store #(.ENTRIES(L2_ENTRIES), .LINE_BYTES(LINE_BYTES), .TAG_BITS(TB)) u_l2 (
        .i_clk, .i_rst_n, .i_raddr(l2_raddr), .o_rvalid(l2_v), .o_rtag(l2_tag),
        .o_rage(l2_age), .i_braddr(l2_braddr), .o_rbyte(l2_byte), .i_mwe(l2_mwe),
        .i_maddr(l2_maddr), .i_mtag(l2_mtag), .i_mage(l2_mage), .i_bwe(l2_bwe),
        .i_bwaddr(l2_bwaddr), .i_bwdata(l2_bwdata), .o_clearing(l2_clr));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_L1RD;
            S_L1RD: n_state = S_L1CK;
            S_L1CK: begin
                if (!r_op && l1_v && l1_tag == r_line) n_state = S_L1BY;
                else if (32'(r_idx) == L1_WAYS - 1) n_state = r_op ? S_WWR : S_L2RD;
                else n_state = S_L1RD;
            end
            S_L1BY: n_state = S_OUT;
            S_L2RD: n_state = S_L2CK;
            S_L2CK: begin
                if (r_op) n_state = (32'(r_idx) == L2_ENTRIES - 1) ? S_WWR : S_L2RD;
                else if (l2_v && l2_tag == r_line) n_state = S_L2BY;
                else if (32'(r_idx) == L2_ENTRIES - 1) n_state = S_OUT;
                else n_state = S_L2RD;
            end
            S_L2BY: n_state = S_BYW;
            S_BYW: n_state = r_has_inv ? S_FRD : S_OUT;
            S_FRD: n_state = S_FWR;
            S_FWR: n_state = (32'(r_bcnt) == LINE_BYTES - 1) ? S_OUT : S_FRD;
            S_WWR: n_state = r_lvl2 ? S_OUT : S_L2RD;
            S_OUT: if (deliver) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_l1h <= 1'b0; r_l2h <= 1'b0; r_rd <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_op <= i_operation;
                    r_line <= TB'(i_address[ADDRESS_BITS-1:OB]);
                    r_off <= i_address[OB-1:0];
                    r_wdata <= i_write_data;
                    r_idx <= '0; r_bcnt <= '0; r_lvl2 <= 1'b0;
                    r_has_inv <= 1'b0; r_cand <= '0; r_cand_age <= '0;
                    r_l1h <= 1'b0; r_l2h <= 1'b0; r_rd <= '0;
                end
                S_L1CK: begin
                    if (!l1_v && !r_has_inv) begin
                        r_has_inv <= 1'b1; r_inv_way <= way;
                    end
                    if (r_idx == '0 || !l1_v || l1_age < r_cand_age) begin
                        r_cand <= L2A'(way); r_cand_age <= l1_age;
                    end
                    if (!r_op && l1_v && l1_tag == r_line) r_l1h <= 1'b1;
                    if (32'(r_idx) == L1_WAYS - 1) r_idx <= '0;
                    else r_idx <= r_idx + 1'b1;
                end
                S_L1BY: r_rd <= l1_byte;
                S_L2CK: begin
                    if (r_idx == '0 || !l2_v || l2_age < r_cand_age) begin
                        r_cand <= L2A'(r_idx); r_cand_age <= l2_age;
                    end
                    if (!r_op && l2_v && l2_tag == r_line) begin
                        r_hit <= L2A'(r_idx); r_hit_age <= bump(l2_age); r_l2h <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_BYW: r_rd <= l2_byte;
                S_FWR: r_bcnt <= r_bcnt + 1'b1;
                S_WWR: begin
                    r_lvl2 <= 1'b1; r_idx <= '0; r_cand <= '0; r_cand_age <= '0;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_l1_hit && o_l2_hit)) else $error("both hit flags set");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_l1_hit && !o_l2_hit) |-> (o_read_data == 8'd0))
        else $error("data on miss");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input taken while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_read_data)))
        else $error("stalled result changed");
`endif
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the two-level cache access unit.
`timescale 1ns / 1ps

module testbench;

    localparam int SETS      = 16;
    localparam int WAYS      = 4;
    localparam int L1_LINES  = SETS * WAYS;
    localparam int L2_COUNT  = 64;
    localparam int LINE_LEN  = 16;
    localparam int N_RANDOM  = 530;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic       l1_hit;
        logic       l2_hit;
        logic [7:0] read_data;
    } t_outcome;

    typedef struct packed {
        logic        op;
        logic [31:0] addr;
        logic [7:0]  data;
        logic        chk;
        t_outcome    want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_operation;
    logic [31:0] i_address;
    logic [7:0]  i_write_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_l1_hit;
    logic        o_l2_hit;
    logic [7:0]  o_read_data;

    two_level_cache_access_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_address   (i_address),
        .i_write_data(i_write_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_l1_hit    (o_l1_hit),
        .o_l2_hit    (o_l2_hit),
        .o_read_data (o_read_data)
    );

    logic                 l1_vld [L1_LINES];
    logic [27:0]          l1_tag [L1_LINES];
    tlca_pkg::t_age       l1_age [L1_LINES];
    logic [7:0]           l1_mem [L1_LINES*LINE_LEN];
    logic                 l2_vld [L2_COUNT];
    logic [27:0]          l2_tag [L2_COUNT];
    tlca_pkg::t_age       l2_age [L2_COUNT];
    logic [7:0]           l2_mem [L2_COUNT*LINE_LEN];

    t_outcome pending_results[$];
    t_row     fixed_rows[$];
    logic [31:0] hot_addrs[$];
    int errors = 0;
    int n_accepted = 0;
    int n_delivered = 0;
    int n_l1_hits = 0;
    int n_l2_hits = 0;
    int idle_cycles = 0;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic tlca_pkg::t_age age_bump(tlca_pkg::t_age a);
        return (a == tlca_pkg::AGE_MAX) ? a : tlca_pkg::t_age'(a + 1);
    endfunction

    function automatic t_outcome cache_access(logic op, logic [31:0] addr, logic [7:0] d);
        t_outcome r;
        logic [27:0] ln;
        int off, base, cand, k;
        logic found;
        r = '0;
        ln = addr[31:4];
        off = addr[3:0];
        base = (ln % SETS) * WAYS;
        if (op == tlca_pkg::OP_READ) begin
            found = 1'b0;
            for (int w = 0; w < WAYS && !found; w++) begin
                k = base + w;
                if (l1_vld[k] && l1_tag[k] == ln) begin
                    l1_age[k] = age_bump(l1_age[k]);
                    r.read_data = l1_mem[k*LINE_LEN+off];
                    r.l1_hit = 1'b1;
                    found = 1'b1;
                end
            end
            for (int i = 0; i < L2_COUNT && !found; i++) begin
                if (l2_vld[i] && l2_tag[i] == ln) begin
                    l2_age[i] = age_bump(l2_age[i]);
                    r.read_data = l2_mem[i*LINE_LEN+off];
                    r.l2_hit = 1'b1;
                    found = 1'b1;
                    for (int w = 0; w < WAYS; w++) begin
                        k = base + w;
                        if (!l1_vld[k]) begin
                            l1_vld[k] = 1'b1;
                            l1_tag[k] = l2_tag[i];
                            l1_age[k] = l2_age[i];
                            for (int b = 0; b < LINE_LEN; b++)
                                l1_mem[k*LINE_LEN+b] = l2_mem[i*LINE_LEN+b];
                            break;
                        end
                    end
                end
            end
        end else begin
            cand = 0;
            for (int w = 0; w < WAYS; w++)
                if (!l1_vld[base+w] || l1_age[base+w] < l1_age[base+cand]) cand = w;
            k = base + cand;
            l1_vld[k] = 1'b1;
            l1_tag[k] = ln;
            l1_age[k] = '0;
            l1_mem[k*LINE_LEN+off] = d;
            cand = 0;
            for (int i = 0; i < L2_COUNT; i++)
                if (!l2_vld[i] || l2_age[i] < l2_age[cand]) cand = i;
            l2_vld[cand] = 1'b1;
            l2_tag[cand] = ln;
            l2_age[cand] = '0;
            l2_mem[cand*LINE_LEN+off] = d;
        end
        return r;
    endfunction

    task automatic send_item(logic op, logic [31:0] addr, logic [7:0] d, logic chk, t_outcome w);
        t_outcome p;
        p = cache_access(op, addr, d);
        if (chk && p != w) begin
            $error("table row disagrees with predictor: table %h predictor %h", w, p);
            errors++;
        end
        pending_results.push_back(p);
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_address    <= addr;
        i_write_data <= d;
        do @(posedge i_clk); while (o_in_stall);
        n_accepted++;
    endtask

    task automatic pause_maybe(ref int burst);
        int gap;
        if (burst > 0) begin
            burst--;
            return;
        end
        burst = $urandom_range(0, 12);
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 150) : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_operation <= 1'($urandom);
            i_address <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_addr();
        int s;
        s = $urandom_range(0, 9);
        if (s < 5 && hot_addrs.size() > 0)
            return {hot_addrs[$urandom_range(0, hot_addrs.size()-1)][31:4], 4'($urandom)};
        if (s < 8)
            return {4'($urandom_range(0, 2)), 16'h0, 4'($urandom_range(0, 7)),
                    4'($urandom), 4'($urandom)};
        return $urandom;
    endfunction

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                got = {o_l1_hit, o_l2_hit, o_read_data};
                n_delivered++;
                if (got.l1_hit) n_l1_hits++;
                if (got.l2_hit) n_l2_hits++;
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: %h", got);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.l1_hit !== want.l1_hit) begin
                        $error("l1_hit expected %0d actual %0d", want.l1_hit, got.l1_hit);
                        errors++;
                    end
                    if (got.l2_hit !== want.l2_hit) begin
                        $error("l2_hit expected %0d actual %0d", want.l2_hit, got.l2_hit);
                        errors++;
                    end
                    if (got.read_data !== want.read_data) begin
                        $error("read_data expected %h actual %h", want.read_data,
                               got.read_data);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        int ph;
        ph = n_delivered % 64;
        if (ph < 20) i_out_stall <= 1'b0;
        else if (ph < 40) i_out_stall <= ($urandom_range(0, 3) == 0);
        else i_out_stall <= ($urandom_range(0, 1) == 0) ? 1'($urandom_range(0, 9) < 8) : 1'b0;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog: no progress for %0d cycles", WDOG_MAX);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int burst;
        logic [31:0] a;
        logic op;
        logic [7:0] d;
        t_row row;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = tlca_pkg::OP_READ;
        i_address = '0;
        i_write_data = '0;
        for (int k = 0; k < L1_LINES; k++) begin
            l1_vld[k] = 0; l1_tag[k] = 0; l1_age[k] = 0;
        end
        for (int k = 0; k < L2_COUNT; k++) begin
            l2_vld[k] = 0; l2_tag[k] = 0; l2_age[k] = 0;
        end
        foreach (l1_mem[k]) l1_mem[k] = 0;
        foreach (l2_mem[k]) l2_mem[k] = 0;

        // read misses after reset, extremes, writes then hits, L1 set overflow
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'h0000_0000, 8'h00, 1'b1, '0});
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'hFFFF_FFFF, 8'hFF, 1'b1, '0});
        fixed_rows.push_back('{tlca_pkg::OP_WRITE, 32'h0000_0000, 8'hFF, 1'b1, '0});
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'h0000_0000, 8'h00, 1'b1,
                               '{1'b1, 1'b0, 8'hFF}});
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'h0000_0001, 8'h00, 1'b1,
                               '{1'b1, 1'b0, 8'h00}});
        fixed_rows.push_back('{tlca_pkg::OP_WRITE, 32'hFFFF_FFFF, 8'hA5, 1'b1, '0});
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'hFFFF_FFFF, 8'h00, 1'b1,
                               '{1'b1, 1'b0, 8'hA5}});
        fixed_rows.push_back('{tlca_pkg::OP_WRITE, 32'h0000_0100, 8'h11, 1'b1, '0});
        fixed_rows.push_back('{tlca_pkg::OP_WRITE, 32'h0000_0200, 8'h22, 1'b1, '0});
        fixed_rows.push_back('{tlca_pkg::OP_WRITE, 32'h0000_0300, 8'h33, 1'b1, '0});
        fixed_rows.push_back('{tlca_pkg::OP_WRITE, 32'h0000_0400, 8'h44, 1'b0, '0});
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'h0000_0000, 8'h00, 1'b0, '0});
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'h0000_0100, 8'h00, 1'b0, '0});
        fixed_rows.push_back('{tlca_pkg::OP_WRITE, 32'h0000_0100, 8'h55, 1'b0, '0});
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'h0000_0100, 8'h00, 1'b0, '0});
        fixed_rows.push_back('{tlca_pkg::OP_WRITE, 32'h8000_000F, 8'h80, 1'b0, '0});
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'h8000_000F, 8'h00, 1'b0, '0});
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'h8000_0000, 8'h00, 1'b0, '0});
        fixed_rows.push_back('{tlca_pkg::OP_READ,  32'h7654_3210, 8'h00, 1'b1, '0});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (fixed_rows[r]) begin
            row = fixed_rows[r];
            send_item(row.op, row.addr, row.data, row.chk, row.want);
        end
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            pause_maybe(burst);
            op = ($urandom_range(0, 9) < 4) ? tlca_pkg::OP_WRITE : tlca_pkg::OP_READ;
            a = pick_addr();
            d = 8'($urandom);
            if (op == tlca_pkg::OP_WRITE) begin
                if (hot_addrs.size() >= 24) void'(hot_addrs.pop_front());
                hot_addrs.push_back(a);
            end
            send_item(op, a, d, 1'b0, '0);
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d items: %0d L1 hits, %0d L2 hits, random stalls on both sides",
                 n_accepted, n_l1_hits, n_l2_hits);
        if (errors == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
